// ===== src/tesl_pkg.sv =====
// Package: shared sizes, codes, beat types and ring helpers for the search list table.
package tesl_pkg;

   localparam int DEPTH  = 256;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_SEARCH = 2'd1,
      OP_ALTER  = 2'd2,
      OP_READ   = 2'd3
   } tesl_op_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_RANGE     = 2'd3
   } tesl_status_type;

   typedef struct packed {
      tesl_op_type        req_type;
      logic signed [31:0] key_value;
      logic signed [31:0] replacement;
      logic [7:0]         read_position;
   } tesl_req_type;

   typedef struct packed {
      tesl_status_type    status;
      logic [7:0]         match_position;
      logic signed [31:0] entry_value;
      logic [8:0]         occupancy;
   } tesl_result_type;

   // one write port, two read ports
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic [ADDR_W-1:0] rd_addr_a;
      logic [ADDR_W-1:0] rd_addr_b;
   } tesl_ram_cmd_type;

   // ring slot of position pos when the front sits at base
   function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] base,
                                                 input logic [ADDR_W-1:0] pos);
      logic [ADDR_W:0] sum;
      sum = {1'b0, base} + {1'b0, pos};
      if (sum >= (ADDR_W+1)'(DEPTH)) begin
         sum = sum - (ADDR_W+1)'(DEPTH);
      end
      return sum[ADDR_W-1:0];
   endfunction

   // slot one step toward the front (wraps)
   function automatic logic [ADDR_W-1:0] slot_dec(input logic [ADDR_W-1:0] base);
      logic [ADDR_W-1:0] res;
      if (base == '0) begin
         res = ADDR_W'(DEPTH - 1);
      end else begin
         res = base - 1'b1;
      end
      return res;
   endfunction

endpackage

// ===== src/tesl_if.sv =====
// Interfaces: request and response channels of the search list table.
interface tesl_req_if
   import tesl_pkg::*;
();
   logic               valid;
   logic               ready;
   tesl_op_type        req_type;
   logic signed [31:0] key_value;
   logic signed [31:0] replacement;
   logic [7:0]         read_position;

   modport source (output valid, req_type, key_value, replacement, read_position,
                   input ready);
   modport sink   (input valid, req_type, key_value, replacement, read_position,
                   output ready);
endinterface

interface tesl_rsp_if
   import tesl_pkg::*;
();
   logic               valid;
   logic               ready;
   tesl_status_type    status;
   logic [7:0]         match_position;
   logic signed [31:0] entry_value;
   logic [8:0]         occupancy;

   modport source (output valid, status, match_position, entry_value, occupancy,
                   input ready);
   modport sink   (input valid, status, match_position, entry_value, occupancy,
                   output ready);
endinterface

// ===== src/tesl_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
module tesl_ram #(
   parameter int DATA_W = 32,
   parameter int WORDS  = 256,
   parameter int AW     = (WORDS > 1) ? $clog2(WORDS) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [AW-1:0]     rd_addr_a,
   input  logic [AW-1:0]     rd_addr_b,
   output logic [DATA_W-1:0] rd_data_a,
   output logic [DATA_W-1:0] rd_data_b
);

   logic [DATA_W-1:0] mem [WORDS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// ===== src/tesl_seq.sv =====
// Sequencer: ring pointers, two-ended search and request handling over the entry RAM.
module tesl_seq
   import tesl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tesl_req_type      req,
   output logic              res_valid,
   input  logic              res_ready,
   output tesl_result_type   res,
   output tesl_ram_cmd_type  ram_cmd,
   input  logic [DATA_W-1:0] rd_data_a,
   input  logic [DATA_W-1:0] rd_data_b
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_READ,
      S_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] fp_ff, fp_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   tesl_op_type       op_ff, op_in;
   logic [DATA_W-1:0] key_ff, key_in;
   logic [DATA_W-1:0] repl_ff, repl_in;
   logic [ADDR_W-1:0] rpos_ff, rpos_in;
   logic              iss_act_ff, iss_act_in;
   logic [ADDR_W-1:0] iss_lo_ff, iss_lo_in;
   logic [ADDR_W-1:0] iss_hi_ff, iss_hi_in;
   logic              cmp_act_ff, cmp_act_in;
   logic [ADDR_W-1:0] cmp_lo_ff, cmp_lo_in;
   logic [ADDR_W-1:0] cmp_hi_ff, cmp_hi_in;
   tesl_result_type   res_ff, res_in;

   localparam int CMP_W = CNT_W + 8;

   logic              req_fire;
   logic              found;
   logic [ADDR_W-1:0] found_pos;
   logic [DATA_W-1:0] found_val;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign res_valid = (state_ff == S_DONE);
   assign res       = res_ff;

   always_comb begin
      state_in   = state_ff;
      fp_in      = fp_ff;
      count_in   = count_ff;
      op_in      = op_ff;
      key_in     = key_ff;
      repl_in    = repl_ff;
      rpos_in    = rpos_ff;
      iss_act_in = iss_act_ff;
      iss_lo_in  = iss_lo_ff;
      iss_hi_in  = iss_hi_ff;
      cmp_act_in = cmp_act_ff;
      cmp_lo_in  = cmp_lo_ff;
      cmp_hi_in  = cmp_hi_ff;
      res_in     = res_ff;
      found      = 1'b0;
      found_pos  = cmp_lo_ff;
      found_val  = rd_data_a;

      ram_cmd.wr_en     = 1'b0;
      ram_cmd.wr_addr   = slot_of(fp_ff, cmp_lo_ff);
      ram_cmd.wr_data   = repl_ff;
      ram_cmd.rd_addr_a = slot_of(fp_ff, iss_lo_ff);
      ram_cmd.rd_addr_b = slot_of(fp_ff, iss_hi_ff);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in   = req.req_type;
               key_in  = req.key_value;
               repl_in = req.replacement;
               res_in.match_position = '0;
               res_in.entry_value    = '0;
               res_in.occupancy      = 9'(count_ff);
               case (req.req_type)
                  OP_INSERT: begin
                     if (count_ff == CNT_W'(DEPTH)) begin
                        res_in.status = ST_FULL;
                     end else begin
                        fp_in            = slot_dec(fp_ff);
                        count_in         = count_ff + 1'b1;
                        ram_cmd.wr_en    = 1'b1;
                        ram_cmd.wr_addr  = slot_dec(fp_ff);
                        ram_cmd.wr_data  = req.key_value;
                        res_in.status    = ST_DONE;
                        res_in.occupancy = 9'(count_ff + 1'b1);
                     end
                     state_in = S_DONE;
                  end
                  OP_SEARCH, OP_ALTER: begin
                     if (count_ff == '0) begin
                        res_in.status = ST_NOT_FOUND;
                        state_in      = S_DONE;
                     end else begin
                        iss_act_in = 1'b1;
                        iss_lo_in  = '0;
                        iss_hi_in  = ADDR_W'(count_ff - 1'b1);
                        cmp_act_in = 1'b0;
                        state_in   = S_SEARCH;
                     end
                  end
                  default: begin
                     if (CMP_W'(req.read_position) < CMP_W'(count_ff)) begin
                        rpos_in           = ADDR_W'(req.read_position);
                        ram_cmd.rd_addr_a = slot_of(fp_ff, ADDR_W'(req.read_position));
                        state_in          = S_READ;
                     end else begin
                        res_in.status = ST_RANGE;
                        state_in      = S_DONE;
                     end
                  end
               endcase
            end
         end
         S_READ: begin
            res_in.status         = ST_DONE;
            res_in.match_position = 8'(rpos_ff);
            res_in.entry_value    = rd_data_a;
            res_in.occupancy      = 9'(count_ff);
            state_in              = S_DONE;
         end
         S_SEARCH: begin
            // issue side: read front and back probes, step toward the middle
            cmp_act_in = iss_act_ff;
            cmp_lo_in  = iss_lo_ff;
            cmp_hi_in  = iss_hi_ff;
            if (iss_act_ff) begin
               iss_act_in = ({1'b0, iss_lo_ff} + (ADDR_W+1)'(2)) <= {1'b0, iss_hi_ff};
               iss_lo_in  = iss_lo_ff + 1'b1;
               iss_hi_in  = iss_hi_ff - 1'b1;
            end
            // compare side: data for the step issued last cycle, front first
            if (cmp_act_ff) begin
               if (rd_data_a == key_ff) begin
                  found     = 1'b1;
                  found_pos = cmp_lo_ff;
                  found_val = rd_data_a;
               end else if (rd_data_b == key_ff) begin
                  found     = 1'b1;
                  found_pos = cmp_hi_ff;
                  found_val = rd_data_b;
               end
               if (found) begin
                  res_in.status         = ST_DONE;
                  res_in.match_position = 8'(found_pos);
                  res_in.entry_value    = found_val;
                  res_in.occupancy      = 9'(count_ff);
                  ram_cmd.wr_en         = (op_ff == OP_ALTER);
                  ram_cmd.wr_addr       = slot_of(fp_ff, found_pos);
                  iss_act_in            = 1'b0;
                  cmp_act_in            = 1'b0;
                  state_in              = S_DONE;
               end else if (!iss_act_ff) begin
                  res_in.status         = ST_NOT_FOUND;
                  res_in.match_position = '0;
                  res_in.entry_value    = '0;
                  res_in.occupancy      = 9'(count_ff);
                  cmp_act_in            = 1'b0;
                  state_in              = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         fp_ff      <= '0;
         count_ff   <= '0;
         iss_act_ff <= 1'b0;
         cmp_act_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fp_ff      <= fp_in;
         count_ff   <= count_in;
         iss_act_ff <= iss_act_in;
         cmp_act_ff <= cmp_act_in;
      end
      op_ff     <= op_in;
      key_ff    <= key_in;
      repl_ff   <= repl_in;
      rpos_ff   <= rpos_in;
      iss_lo_ff <= iss_lo_in;
      iss_hi_ff <= iss_hi_in;
      cmp_lo_ff <= cmp_lo_in;
      cmp_hi_ff <= cmp_hi_in;
      res_ff    <= res_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above table depth");

   assert property (@(posedge clock) disable iff (reset)
      req_fire && (req.req_type == OP_INSERT) && (count_ff != CNT_W'(DEPTH))
      |=> (count_ff == CNT_W'($past(count_ff) + 1'b1)) && (fp_ff == slot_dec($past(fp_ff))))
      else $error("insert did not advance front and count");

   assert property (@(posedge clock) disable iff (reset)
      ram_cmd.wr_en |-> (state_ff == S_SEARCH && op_ff == OP_ALTER) ||
                        (req_fire && req.req_type == OP_INSERT))
      else $error("stray RAM write");

   assert property (@(posedge clock) disable iff (reset)
      (iss_act_ff || cmp_act_ff) |-> (state_ff == S_SEARCH))
      else $error("probe pipeline busy outside search");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE && state_ff != S_DONE) |=> $stable(count_ff) && $stable(fp_ff))
      else $error("ring state moved during search or read");

endmodule

// ===== src/two_ended_search_list_table.sv =====
// Top level: ordered signed-value table in a RAM ring with two-ended search.
//
// Keeps up to DEPTH (256) signed 32-bit values in a ring held in one RAM with
// one write and two read ports; insert puts a value at the front (position 0),
// search and alter probe from the front and the back toward the middle, front
// probe first at each step, and read returns the entry at a given position.
// Every request beat gives exactly one response beat carrying status, position,
// value (before alter) and occupancy. One request is in work at a time.
// Search/alter run time grows with the step, counted from one, at which the
// match lands; a miss over n entries walks all ceil(n/2) steps, DEPTH/2 = 128
// at worst. The search loop issues one front/back pair of RAM reads per cycle
// and compares the pair read in the previous cycle; the two RAM read ports set
// that pace. The RAM powers up with arbitrary contents and needs no clearing
// pass: only slots that hold entries are ever compared or returned.
// A response beat parks in an output register, so the next request can be
// taken while the previous response waits for the sink.
module two_ended_search_list_table
   import tesl_pkg::*;
(
   input logic       clock,
   input logic       reset,
   tesl_req_if.sink  req_bus,
   tesl_rsp_if.source rsp_bus
);

   tesl_req_type     req;
   tesl_result_type  res;
   logic             res_valid;
   logic             res_ready;
   tesl_ram_cmd_type ram_cmd;
   logic [DATA_W-1:0] rd_data_a;
   logic [DATA_W-1:0] rd_data_b;

   // output beat register
   logic             out_valid_ff, out_valid_in;
   tesl_result_type  out_ff, out_in;

   assign req.req_type      = req_bus.req_type;
   assign req.key_value     = req_bus.key_value;
   assign req.replacement   = req_bus.replacement;
   assign req.read_position = req_bus.read_position;

   tesl_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .req       (req),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .ram_cmd   (ram_cmd),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   tesl_ram #(
      .DATA_W (DATA_W),
      .WORDS  (DEPTH)
   ) u_ram (
      .clock     (clock),
      .wr_en     (ram_cmd.wr_en),
      .wr_addr   (ram_cmd.wr_addr),
      .wr_data   (ram_cmd.wr_data),
      .rd_addr_a (ram_cmd.rd_addr_a),
      .rd_addr_b (ram_cmd.rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // the register takes a new beat when empty or being drained this cycle
   assign res_ready = !out_valid_ff || rsp_bus.ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (res_valid && res_ready) begin
         out_valid_in = 1'b1;
         out_in       = res;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.status         = out_ff.status;
   assign rsp_bus.match_position = out_ff.match_position;
   assign rsp_bus.entry_value    = out_ff.entry_value;
   assign rsp_bus.occupancy      = out_ff.occupancy;

endmodule

// ===== verif/tesl_result_checker.sv =====
// Checker: table predictor and response comparison for the search list table.
`timescale 1ns / 100ps

module tesl_result_checker
   import tesl_pkg::*;
(
   input  logic clock,
   input  logic reset,
   tesl_req_if  req_mon,
   tesl_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending_count
);

   // shadow copy of the ring
   logic signed [31:0] shadow_ring [DEPTH];
   int unsigned        shadow_front;
   int unsigned        shadow_held;
   tesl_result_type    pending_results [$];

   function automatic int unsigned ring_slot(input int unsigned pos);
      return (shadow_front + pos) % DEPTH;
   endfunction

   // Applies one request to the shadow table, returns the response it should give.
   function automatic tesl_result_type predict_table_result(input tesl_req_type rq);
      tesl_result_type res;
      int unsigned     lo;
      int unsigned     hi;
      int unsigned     hit;
      bit              found;
      bit              exhausted;
      res        = '0;
      res.status = ST_DONE;
      case (rq.req_type)
         OP_INSERT: begin
            if (shadow_held >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
               shadow_ring[shadow_front] = rq.key_value;
               shadow_held++;
            end
         end
         OP_SEARCH, OP_ALTER: begin
            found     = 1'b0;
            exhausted = (shadow_held == 0);
            hit       = 0;
            lo        = 0;
            hi        = (shadow_held == 0) ? 0 : shadow_held - 1;
            // front probe before back probe at each step
            while (!found && !exhausted) begin
               if (shadow_ring[ring_slot(lo)] == rq.key_value) begin
                  found = 1'b1;
                  hit   = lo;
               end else if (shadow_ring[ring_slot(hi)] == rq.key_value) begin
                  found = 1'b1;
                  hit   = hi;
               end else if (lo + 2 > hi) begin
                  exhausted = 1'b1;
               end else begin
                  lo++;
                  hi--;
               end
            end
            if (found) begin
               res.match_position = 8'(hit);
               res.entry_value    = shadow_ring[ring_slot(hit)];
               if (rq.req_type == OP_ALTER) begin
                  shadow_ring[ring_slot(hit)] = rq.replacement;
               end
            end else begin
               res.status = ST_NOT_FOUND;
            end
         end
         default: begin
            if (rq.read_position < shadow_held) begin
               res.match_position = rq.read_position;
               res.entry_value    = shadow_ring[ring_slot(rq.read_position)];
            end else begin
               res.status = ST_RANGE;
            end
         end
      endcase
      res.occupancy = 9'(shadow_held);
      return res;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : watch
      tesl_req_type    req_beat;
      tesl_result_type want;
      if (reset) begin
         shadow_front = 0;
         shadow_held  = 0;
         pending_results.delete();
      end else begin
         // a response beat always belongs to an earlier request
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_results.size() == 0) begin
               $error("response beat with no request outstanding");
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_mon.status));
               check_field("match_position", 32'(want.match_position),
                           32'(rsp_mon.match_position));
               check_field("entry_value", want.entry_value, rsp_mon.entry_value);
               check_field("occupancy", 32'(want.occupancy), 32'(rsp_mon.occupancy));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            req_beat.req_type      = req_mon.req_type;
            req_beat.key_value     = req_mon.key_value;
            req_beat.replacement   = req_mon.replacement;
            req_beat.read_position = req_mon.read_position;
            pending_results.push_back(predict_table_result(req_beat));
         end
      end
      pending_count <= pending_results.size();
   end

endmodule

// ===== verif/two_ended_search_list_table_test.sv =====
// Testbench top: clock, reset, request stimulus, response stalls and verdict.
`timescale 1ns / 100ps

module two_ended_search_list_table_test;
   import tesl_pkg::*;

   // Random beats per idling phase; four phases plus the directed opener
   // come to roughly 1250 requests.
   localparam int PHASE_BEATS = 310;
   // Worst correct run is near 1250 worst-case searches plus stall/gap slack;
   // this limit is several times that.
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int TAIL_CYCLES = 150;

   logic clock;
   logic reset;
   int   gap_pct   = 0;   // chance per cycle that the sender holds off
   int   stall_pct = 0;   // chance per cycle that the response side stalls
   int   cycle_count = 0;
   int   fail_count;
   int   pending_count;

   // Values lately sent as inserts or alter replacements (the last 48); searches
   // mostly aim at these so hits land all over the ring, duplicates included.
   logic signed [31:0] seen_values [$];

   tesl_req_if req_bus ();
   tesl_rsp_if rsp_bus ();

   two_ended_search_list_table dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   tesl_result_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Response side: ready redrawn every cycle from the current stall rate.
   always @(posedge clock) begin
      rsp_bus.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
   end

   // Mostly plain random words, now and then one of the extremes.
   function automatic logic signed [31:0] random_value();
      case ($urandom_range(19))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return 32'sh0000_0000;
         3:       return 32'shffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [31:0] known_value();
      if (seen_values.size() == 0 || $urandom_range(99) < 20) begin
         return random_value();
      end
      return seen_values[$urandom_range(seen_values.size() - 1)];
   endfunction

   function automatic void remember_value(input logic signed [31:0] v);
      seen_values.push_back(v);
      if (seen_values.size() > 48) begin
         void'(seen_values.pop_front());
      end
   endfunction

   // Puts one request beat on the bus and returns at the edge that takes it.
   // valid stays high into the next call, so back-to-back beats need no
   // drop; an idle cycle drives it low exactly once per step.
   task automatic send_request(input tesl_op_type op, input logic signed [31:0] key,
                               input logic signed [31:0] repl, input logic [7:0] pos);
      while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.req_type      <= op;
      req_bus.key_value     <= key;
      req_bus.replacement   <= repl;
      req_bus.read_position <= pos;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      if (op == OP_INSERT) begin
         remember_value(key);
      end else if (op == OP_ALTER) begin
         remember_value(repl);
      end
   endtask

   // Insert-heavy mix: the table fills partway through the run, after which
   // inserts come back flagged full and searches cover the whole ring.
   task automatic send_random_request();
      int unsigned        pick;
      tesl_op_type        op;
      logic signed [31:0] key;
      logic [7:0]         pos;
      pick = $urandom_range(99);
      if (pick < 40) begin
         op = OP_INSERT;
      end else if (pick < 65) begin
         op = OP_SEARCH;
      end else if (pick < 80) begin
         op = OP_ALTER;
      end else begin
         op = OP_READ;
      end
      if (op == OP_INSERT && $urandom_range(3) != 0) begin
         key = random_value();
      end else begin
         key = known_value();
      end
      if ($urandom_range(1) != 0) begin
         pos = 8'($urandom_range(255));
      end else begin
         pos = 8'($urandom_range(31));
      end
      send_request(op, key, random_value(), pos);
   endtask

   // Drop valid and hold off until every response is back. The first edge is
   // taken before looking, since the count is a registered copy of the queue size.
   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (pending_count != 0);
   endtask

   initial begin
      int gap_plan   [4] = '{0, 54, 0, 28};
      int stall_plan [4] = '{0, 0, 54, 28};
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.req_type      <= OP_INSERT;
      req_bus.key_value     <= '0;
      req_bus.replacement   <= '0;
      req_bus.read_position <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Empty table: every lookup misses, every read is out of range.
      send_request(OP_READ,   32'sd0, 32'sd0, 8'd0);
      send_request(OP_SEARCH, 32'sd0, 32'sd0, 8'd0);
      send_request(OP_ALTER,  32'sd0, 32'sd1, 8'd0);
      // One entry: search must check it, both the hit and the miss.
      send_request(OP_INSERT, 32'sh7fff_ffff, 32'sd0, 8'd0);
      send_request(OP_SEARCH, 32'sh7fff_ffff, 32'sd0, 8'd0);
      send_request(OP_SEARCH, 32'sh8000_0000, 32'sd0, 8'd0);
      send_request(OP_READ,   32'sd0, 32'sd0, 8'd0);
      send_request(OP_READ,   32'sd0, 32'sd0, 8'd1);
      send_request(OP_READ,   32'sd0, 32'sd0, 8'd255);
      // Duplicates: table becomes MAX, MIN, MAX; front probe wins at step 0.
      send_request(OP_INSERT, 32'sh8000_0000, 32'sd0, 8'd0);
      send_request(OP_INSERT, 32'sh7fff_ffff, 32'sd0, 8'd0);
      send_request(OP_SEARCH, 32'sh7fff_ffff, 32'sd0, 8'd0);
      // With 5 in front the back copy of MAX matches at the earlier step.
      send_request(OP_INSERT, 32'sd5, 32'sd0, 8'd0);
      send_request(OP_SEARCH, 32'sh7fff_ffff, 32'sd0, 8'd0);
      send_request(OP_SEARCH, 32'sh8000_0000, 32'sd0, 8'd0);
      // Alter reports the old value; second alter finds the new one.
      send_request(OP_ALTER,  32'sh7fff_ffff, 32'shffff_ffff, 8'd0);
      send_request(OP_ALTER,  32'shffff_ffff, 32'sh8000_0000, 8'd0);
      send_request(OP_READ,   32'sd0, 32'sd0, 8'd3);
      send_request(OP_SEARCH, 32'sd12345, 32'sd0, 8'd0);
      send_request(OP_READ,   32'sd0, 32'sd0, 8'd4);
      drain_responses();

      // Random phases: no idling, sender gaps, response stalls, then both.
      // Each phase ends with a full drain before the next starts.
      for (int ph = 0; ph < 4; ph++) begin
         gap_pct   = gap_plan[ph];
         stall_pct = stall_plan[ph];
         repeat (PHASE_BEATS) send_random_request();
         drain_responses();
      end
      gap_pct   = 0;
      stall_pct = 0;

      // Settle time: a stray extra response beat would show up here.
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
